FILE: hdl/lds_pkg.sv
`timescale 1ns / 1ps

package lds_pkg;

   localparam int PosBits  = 16;
   localparam int SymBits  = 8;
   localparam int SymCount = 1 << SymBits;
   localparam int LenBits  = SymBits + 1;
   localparam int MaxLen   = SymCount;

   typedef logic [PosBits-1:0] pos_type;
   typedef logic [SymBits-1:0] sym_type;
   typedef logic [LenBits-1:0] len_type;

endpackage

FILE: hdl/lds_if.sv
`timescale 1ns / 1ps

interface lds_req_if import lds_pkg::*; ();
   logic    valid;
   logic    ready;
   sym_type symbol;
   logic    symbol_valid;
   logic    last;

   modport source (output valid, output symbol, output symbol_valid, output last,
                   input ready);
   modport sink   (input valid, input symbol, input symbol_valid, input last,
                   output ready);
endinterface

interface lds_rsp_if import lds_pkg::*; ();
   logic    valid;
   logic    ready;
   len_type longest_length;
   logic    too_long;

   modport source (output valid, output longest_length, output too_long, input ready);
   modport sink   (input valid, input longest_length, input too_long, output ready);
endinterface

FILE: hdl/longest_distinct_run_scanner.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle, sustained; a stall happens only when a
// last request meets a full result register that is not drained that cycle.
// Path to a result: the last request and its position-table read register in
// stage 1, and the result register loads as that request leaves stage 1; a
// full result register that is not drained can hold it in stage 1.
// Reset clears all control state and the seen marks at once; the position table
// is not cleared and is read only behind a set seen mark.
module longest_distinct_run_scanner import lds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lds_req_if.sink     req_chan,
   lds_rsp_if.source   rsp_chan
);

   // position table
   pos_type pos_mem [SymCount];
   pos_type rd_pos_ff;

   // stage 1 request
   logic    s1_valid_ff, s1_valid_in;
   sym_type s1_sym_ff;
   logic    s1_symv_ff;
   logic    s1_last_ff;
   logic    s1_go;
   logic    req_take;

   // last table write, for forwarding
   logic    wr_valid_ff;
   sym_type wr_sym_ff;
   pos_type wr_pos_ff;

   // string state
   logic [SymCount-1:0] seen_ff, seen_in;
   pos_type wstart_ff, wstart_in;
   pos_type pos_ff, pos_in;
   len_type cur_len_ff, cur_len_in;
   len_type best_len_ff, best_len_in;
   logic    ovf_ff, ovf_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   len_type rsp_len_ff;
   logic    rsp_ovf_ff;

   pos_type prev_pos;
   pos_type run_len;
   logic    hit;
   logic    sym_take;
   len_type cur_upd, best_upd, result;
   logic    ovf_upd;

   assign s1_go    = !s1_last_ff || !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take = req_chan.valid && req_chan.ready;
   assign sym_take = s1_valid_ff && s1_go && s1_symv_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_pos_ff <= pos_mem[req_chan.symbol];
      end
      if (sym_take) begin
         pos_mem[s1_sym_ff] <= pos_ff;
      end
   end

   always_comb begin
      prev_pos = (wr_valid_ff && (wr_sym_ff == s1_sym_ff)) ? wr_pos_ff : rd_pos_ff;
      hit      = seen_ff[s1_sym_ff] && (prev_pos >= wstart_ff);
      run_len  = pos_ff - prev_pos;

      cur_upd    = cur_len_ff;
      best_upd   = best_len_ff;
      wstart_in  = wstart_ff;
      pos_in     = pos_ff;
      ovf_upd    = ovf_ff;
      seen_in    = seen_ff;

      if (sym_take) begin
         if (hit) begin
            if (cur_len_ff > best_len_ff) begin
               best_upd = cur_len_ff;
            end
            cur_upd   = (run_len > pos_type'(MaxLen)) ? len_type'(MaxLen)
                                                     : len_type'(run_len);
            wstart_in = prev_pos + pos_type'(1);
         end else if (cur_len_ff < len_type'(MaxLen)) begin
            cur_upd = cur_len_ff + len_type'(1);
         end
         seen_in[s1_sym_ff] = 1'b1;
         if (pos_ff == '1) begin
            ovf_upd = 1'b1;
         end
         pos_in = pos_ff + pos_type'(1);
      end

      result = (cur_upd > best_upd) ? cur_upd : best_upd;

      cur_len_in  = cur_upd;
      best_len_in = best_upd;
      ovf_in      = ovf_upd;

      // drop the string state once the result is loaded into the result register
      if (s1_valid_ff && s1_go && s1_last_ff) begin
         seen_in     = '0;
         wstart_in   = '0;
         pos_in      = '0;
         cur_len_in  = '0;
         best_len_in = '0;
         ovf_in      = 1'b0;
      end

      s1_valid_in  = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (s1_valid_ff && s1_go && s1_last_ff) ? 1'b1
                   : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         wstart_ff    <= '0;
         pos_ff       <= '0;
         cur_len_ff   <= '0;
         best_len_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         seen_ff      <= seen_in;
         wstart_ff    <= wstart_in;
         pos_ff       <= pos_in;
         cur_len_ff   <= cur_len_in;
         best_len_ff  <= best_len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (sym_take) begin
            wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sym_ff  <= req_chan.symbol;
         s1_symv_ff <= req_chan.symbol_valid;
         s1_last_ff <= req_chan.last;
      end
      if (sym_take) begin
         wr_sym_ff <= s1_sym_ff;
         wr_pos_ff <= pos_ff;
      end
      if (s1_valid_ff && s1_go && s1_last_ff) begin
         rsp_len_ff <= result;
         rsp_ovf_ff <= ovf_upd;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.longest_length = rsp_len_ff;
   assign rsp_chan.too_long       = rsp_ovf_ff;

   a_cur_len_range: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff <= len_type'(MaxLen))
      else $error("current length above maximum");

   a_best_len_range: assert property (@(posedge clock) disable iff (reset)
      best_len_ff <= len_type'(MaxLen))
      else $error("best length above maximum");

   a_string_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_go && s1_last_ff) |=>
         (seen_ff == '0 && pos_ff == '0 && cur_len_ff == '0 && rsp_valid_ff))
      else $error("string state not cleared at end of string");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_sym_ff)))
      else $error("stalled request lost");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> (rsp_valid_ff && s1_last_ff))
      else $error("stall without full result register");

endmodule
